>>> design/fifo_queue_with_remove_by_value_defines.svh
// Assertion macros for the remove-by-value queue.
`ifndef FIFO_QUEUE_WITH_REMOVE_BY_VALUE_DEFINES_SVH
`define FIFO_QUEUE_WITH_REMOVE_BY_VALUE_DEFINES_SVH
`ifndef SYNTHESIS
`define FQRV_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("queue check failed: same-cycle implication");
`define FQRV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("queue check failed: next-cycle implication");
`else
`define FQRV_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define FQRV_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/fqrv_pkg.sv
// Shared types and constants for the remove-by-value queue.
package fqrv_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        KIND_ENQUEUE = 2'd0,
        KIND_REMOVE  = 2'd1,
        KIND_READOUT = 2'd2,
        KIND_UNUSED  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

endpackage

>>> design/fqrv_ram.sv
// Entry memory: one write port, one read port with registered read data.
module fqrv_ram
    import fqrv_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/fifo_queue_with_remove_by_value.sv
// Bounded FIFO of signed 32-bit values with enqueue, remove-by-value and read-out.
// An enqueue writes its value in the transfer cycle, if there is room, and then loads
// its result. A remove scans from the head with one comparator, a read and a compare
// per entry examined, then closes the gap with a read and a write per entry moved
// behind the match, and then loads its result. A read-out loads the entries from the
// head into the output register one by one while the output side takes them. These
// steps come from the single read port of the entry memory, whose read data is
// registered, feeding the one comparator. in_stall is high from the transfer of an
// item of any kind but KIND_UNUSED until its last result has been loaded into the
// output register; the output register then holds while the next item enters.
module fifo_queue_with_remove_by_value
    import fqrv_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] item_value,
    output logic [1:0]         status,
    output logic               last_item
);

`include "fifo_queue_with_remove_by_value_defines.svh"

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMIT,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_MOVE_RD,
        S_MOVE_WR,
        S_OUT_RD,
        S_OUT_EMIT
    } state_t;

    state_t            state_reg;
    logic [CW-1:0]     count_reg;
    logic [AW-1:0]     idx_reg;
    logic [DATA_W-1:0] value_reg;
    status_t           pend_status_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] item_value_reg;
    status_t           status_reg;
    logic              last_reg;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] rd_data;

    logic              out_free;
    logic              out_load;
    logic              match;
    logic [CW-1:0]     idx_ext;
    logic              at_last;
    logic              move_last;
    logic              in_xfer;

    fqrv_ram #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = out_free && (state_reg == S_EMIT || state_reg == S_OUT_EMIT);
    assign match     = (rd_data == value_reg);
    assign idx_ext   = CW'(idx_reg);
    assign at_last   = ((idx_ext + CW'(1)) == count_reg);
    assign move_last = ((idx_ext + CW'(2)) == count_reg);

    // Memory port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = rd_data;
        ram_re    = 1'b0;
        ram_raddr = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && kind == KIND_ENQUEUE && count_reg != CW'(QUEUE_DEPTH))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = count_reg[AW-1:0];
                    ram_wdata = value;
                end
            end
            S_SEARCH_RD, S_OUT_RD:
            begin
                ram_re = 1'b1;
            end
            S_MOVE_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = idx_reg + AW'(1);
            end
            S_MOVE_WR:
            begin
                ram_we = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            idx_reg         <= '0;
            value_reg       <= '0;
            pend_status_reg <= ST_OK;
            out_valid_reg   <= 1'b0;
            item_value_reg  <= '0;
            status_reg      <= ST_OK;
            last_reg        <= 1'b0;
        end
        else
        begin
            // drop the output register once the far side takes it and nothing new loads
            if (out_valid_reg && !out_stall && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        value_reg <= value;
                        idx_reg   <= '0;
                        unique case (kind)
                            KIND_ENQUEUE:
                            begin
                                if (count_reg == CW'(QUEUE_DEPTH))
                                begin
                                    pend_status_reg <= ST_FULL;
                                end
                                else
                                begin
                                    count_reg       <= count_reg + CW'(1);
                                    pend_status_reg <= ST_OK;
                                end
                                state_reg <= S_EMIT;
                            end
                            KIND_REMOVE:
                            begin
                                if (count_reg == '0)
                                begin
                                    pend_status_reg <= ST_NOT_FOUND;
                                    state_reg       <= S_EMIT;
                                end
                                else
                                begin
                                    state_reg <= S_SEARCH_RD;
                                end
                            end
                            KIND_READOUT:
                            begin
                                if (count_reg == '0)
                                begin
                                    pend_status_reg <= ST_EMPTY;
                                    state_reg       <= S_EMIT;
                                end
                                else
                                begin
                                    state_reg <= S_OUT_RD;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        item_value_reg <= '0;
                        status_reg     <= pend_status_reg;
                        last_reg       <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                S_SEARCH_RD:
                begin
                    state_reg <= S_SEARCH_CMP;
                end
                S_SEARCH_CMP:
                begin
                    if (match)
                    begin
                        pend_status_reg <= ST_OK;
                        if (at_last)
                        begin
                            count_reg <= count_reg - CW'(1);
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_MOVE_RD;
                        end
                    end
                    else if (at_last)
                    begin
                        pend_status_reg <= ST_NOT_FOUND;
                        state_reg       <= S_EMIT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + AW'(1);
                        state_reg <= S_SEARCH_RD;
                    end
                end
                S_MOVE_RD:
                begin
                    state_reg <= S_MOVE_WR;
                end
                S_MOVE_WR:
                begin
                    // entry idx+1 is written into idx this cycle
                    if (move_last)
                    begin
                        count_reg <= count_reg - CW'(1);
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + AW'(1);
                        state_reg <= S_MOVE_RD;
                    end
                end
                S_OUT_RD:
                begin
                    state_reg <= S_OUT_EMIT;
                end
                S_OUT_EMIT:
                begin
                    // hold read data until the output register frees up
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        item_value_reg <= rd_data;
                        status_reg     <= ST_OK;
                        last_reg       <= at_last;
                        if (at_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + AW'(1);
                            state_reg <= S_OUT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign item_value = item_value_reg;
    assign status     = status_reg;
    assign last_item  = last_reg;

    `FQRV_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(QUEUE_DEPTH))
    `FQRV_ASSERT_SAME(a_count_step, clk, rst_n, count_reg != $past(count_reg), (count_reg == $past(count_reg) + CW'(1)) || (count_reg + CW'(1) == $past(count_reg)))
    `FQRV_ASSERT_NEXT(a_item_busy, clk, rst_n, in_xfer && kind != KIND_UNUSED, state_reg != S_IDLE)
    `FQRV_ASSERT_SAME(a_scan_in_range, clk, rst_n, state_reg != S_IDLE && state_reg != S_EMIT, idx_ext < count_reg)

endmodule

>>> tb/fqrv_checker.sv
// Checker for the remove-by-value queue: shadow model, ordered result compare, run counters.
module fqrv_checker
    import fqrv_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         kind,
    input  logic signed [31:0] value,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] item_value,
    input  logic [1:0]         status,
    input  logic               last_item,
    output int                 fails,
    output int                 pending,
    output int                 results_seen,
    output int                 full_seen,
    output int                 miss_seen,
    output int                 empty_seen
);

    typedef struct {
        logic signed [31:0] item_value;
        status_t            status;
        logic               last_item;
    } result_t;

    logic signed [31:0] queued_values[$];
    result_t            awaited_results[$];
    result_t            oldest;

    initial
    begin
        fails        = 0;
        pending      = 0;
        results_seen = 0;
        full_seen    = 0;
        miss_seen    = 0;
        empty_seen   = 0;
    end

    task automatic push_result(input logic signed [31:0] v, input status_t s, input logic l);
        result_t r;
        r.item_value = v;
        r.status     = s;
        r.last_item  = l;
        awaited_results.push_back(r);
    endtask

    // Update the shadow queue for one request and queue the results it owes.
    task automatic apply_request(input logic [1:0] k, input logic signed [31:0] v);
        int hit;
        int count;
        hit   = -1;
        count = queued_values.size();
        case (k)
            KIND_ENQUEUE:
            begin
                if (count >= QUEUE_DEPTH)
                    push_result('0, ST_FULL, 1'b1);
                else
                begin
                    queued_values.push_back(v);
                    push_result('0, ST_OK, 1'b1);
                end
            end
            KIND_REMOVE:
            begin
                for (int i = 0; i < count; i++)
                begin
                    if (queued_values[i] == v)
                    begin
                        hit = i;
                        break;
                    end
                end
                if (hit < 0)
                    push_result('0, ST_NOT_FOUND, 1'b1);
                else
                begin
                    queued_values.delete(hit);
                    push_result('0, ST_OK, 1'b1);
                end
            end
            KIND_READOUT:
            begin
                if (count == 0)
                    push_result('0, ST_EMPTY, 1'b1);
                else
                    for (int i = 0; i < count; i++)
                        push_result(queued_values[i], ST_OK, i == count - 1);
            end
            default:
            begin
                // unused code: no result, no state change
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queued_values.delete();
            awaited_results.delete();
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    fails++;
                    $display("%0t: expected no result, actual item_value %0d status %0d last %0b",
                             $time, item_value, status, last_item);
                end
                else
                begin
                    oldest = awaited_results.pop_front();
                    results_seen++;
                    if (oldest.status == ST_FULL)
                        full_seen++;
                    if (oldest.status == ST_NOT_FOUND)
                        miss_seen++;
                    if (oldest.status == ST_EMPTY)
                        empty_seen++;
                    if (item_value !== oldest.item_value)
                    begin
                        fails++;
                        $display("%0t: item_value expected %0d actual %0d",
                                 $time, oldest.item_value, item_value);
                    end
                    if (status !== oldest.status)
                    begin
                        fails++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, oldest.status, status);
                    end
                    if (last_item !== oldest.last_item)
                    begin
                        fails++;
                        $display("%0t: last_item expected %0b actual %0b",
                                 $time, oldest.last_item, last_item);
                    end
                end
            end
            if (in_valid && !in_stall)
                apply_request(kind, value);
            pending = awaited_results.size();
        end
    end

    // Flag results still owed once the run is over; the top reads fails after this.
    task automatic report_leftovers();
        if (awaited_results.size() != 0)
        begin
            fails += awaited_results.size();
            $display("%0t: %0d results never arrived, oldest item_value %0d status %0d",
                     $time, awaited_results.size(), awaited_results[0].item_value,
                     awaited_results[0].status);
        end
    endtask

endmodule

>>> tb/testbench.sv
// Top of the remove-by-value queue testbench: clock, reset, request traffic and verdict.
module testbench
    import fqrv_pkg::*;
();

    localparam int          DEPTH        = 32;
    localparam int          RANDOM_ITEMS = 400;
    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          DRAIN_CYCLES = 4 * DEPTH + 16;
    localparam int          MAX_STALL    = 12;
    localparam int          POOL_SIZE    = 12;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIX   = 2;

    localparam int RX_FREE     = 0;
    localparam int RX_LIGHT    = 1;
    localparam int RX_HEAVY    = 2;
    localparam int RX_PERIODIC = 3;

    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         kind;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] item_value;
    logic [1:0]         status;
    logic               last_item;

    int fails;
    int pending;
    int results_seen;
    int full_seen;
    int miss_seen;
    int empty_seen;

    int cycles = 0;
    int burst_left = 0;
    bit gaps_on = 1'b1;
    int n_enqueue = 0;
    int n_remove = 0;
    int n_readout = 0;
    int n_unused = 0;

    logic signed [31:0] value_pool [POOL_SIZE];

    fifo_queue_with_remove_by_value #(
        .QUEUE_DEPTH(DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .value(value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .item_value(item_value),
        .status(status),
        .last_item(last_item)
    );

    fqrv_checker #(
        .QUEUE_DEPTH(DEPTH)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .value(value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .item_value(item_value),
        .status(status),
        .last_item(last_item),
        .fails(fails),
        .pending(pending),
        .results_seen(results_seen),
        .full_seen(full_seen),
        .miss_seen(miss_seen),
        .empty_seen(empty_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, pending);
            $display("testbench: errors");
            $finish;
        end
    end

    // Output side: stall on a pattern of a randomly chosen mode, with a cap on streaks.
    int rx_mode = RX_FREE;
    int rx_phase = 0;
    int stall_run = 0;
    always @(negedge clk)
    begin
        if (rx_phase % 100 == 0)
            rx_mode = $urandom_range(RX_FREE, RX_PERIODIC);
        rx_phase++;
        if (stall_run >= MAX_STALL)
            out_stall = 1'b0;
        else
            case (rx_mode)
                RX_LIGHT:    out_stall = ($urandom_range(0, 99) < 25);
                RX_HEAVY:    out_stall = ($urandom_range(0, 99) < 65);
                RX_PERIODIC: out_stall = (rx_phase % 5 < 2);
                default:     out_stall = 1'b0;
            endcase
        stall_run = out_stall ? stall_run + 1 : 0;
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input logic [1:0] k, input logic signed [31:0] v);
        if (gaps_on && burst_left == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 16);
        end
        in_valid = 1'b1;
        kind     = k;
        value    = v;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        in_valid = 1'b0;
        if (burst_left > 0)
            burst_left--;
        case (k)
            KIND_ENQUEUE: n_enqueue++;
            KIND_REMOVE:  n_remove++;
            KIND_READOUT: n_readout++;
            default:      n_unused++;
        endcase
    endtask

    task automatic wait_for_results();
        while (pending != 0)
            @(negedge clk);
    endtask

    // Mostly draw from a small pool so removes find their targets and duplicates occur.
    function automatic logic signed [31:0] pick_value(input int pool_pct);
        if ($urandom_range(0, 99) < pool_pct)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    initial
    begin
        int sent;
        int mode;
        int seg_len;
        int roll;
        int thr_enq;
        int thr_rem;
        int thr_read;
        logic [1:0] k;
        bit first_seg;

        sent      = 0;
        first_seg = 1'b1;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        kind      = KIND_ENQUEUE;
        value     = '0;

        value_pool[0] = VAL_MAX;
        value_pool[1] = VAL_MIN;
        value_pool[2] = '0;
        value_pool[3] = -1;
        for (int i = 4; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;

        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty cases, extremes, duplicates, head/middle/tail removal
        send_item(KIND_READOUT, VAL_MAX);
        send_item(KIND_REMOVE, 5);
        send_item(KIND_ENQUEUE, VAL_MAX);
        send_item(KIND_ENQUEUE, VAL_MIN);
        send_item(KIND_ENQUEUE, 0);
        send_item(KIND_ENQUEUE, -1);
        send_item(KIND_ENQUEUE, 1);
        send_item(KIND_ENQUEUE, VAL_MAX);
        send_item(KIND_READOUT, VAL_MIN);
        send_item(KIND_REMOVE, 42);
        send_item(KIND_REMOVE, VAL_MIN);
        send_item(KIND_REMOVE, VAL_MAX);
        send_item(KIND_READOUT, -1);
        send_item(KIND_UNUSED, -1);
        send_item(KIND_REMOVE, 1);
        send_item(KIND_REMOVE, VAL_MAX);
        send_item(KIND_READOUT, 0);
        send_item(KIND_REMOVE, 0);
        send_item(KIND_REMOVE, -1);
        send_item(KIND_READOUT, 0);
        send_item(KIND_UNUSED, VAL_MIN);
        wait_for_results();

        while (sent < RANDOM_ITEMS)
        begin
            // open with a long fill so the full case is hit early
            mode      = first_seg ? MODE_FILL : $urandom_range(MODE_FILL, MODE_MIX);
            seg_len   = first_seg ? 45 : $urandom_range(20, 60);
            gaps_on   = first_seg ? 1'b0 : ($urandom_range(0, 3) != 0);
            first_seg = 1'b0;
            case (mode)
                MODE_FILL:
                begin
                    thr_enq = 85; thr_rem = 92; thr_read = 98;
                end
                MODE_DRAIN:
                begin
                    thr_enq = 20; thr_rem = 85; thr_read = 96;
                end
                default:
                begin
                    thr_enq = 40; thr_rem = 75; thr_read = 95;
                end
            endcase
            for (int n = 0; n < seg_len && sent < RANDOM_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < thr_enq)
                    k = KIND_ENQUEUE;
                else if (roll < thr_rem)
                    k = KIND_REMOVE;
                else if (roll < thr_read)
                    k = KIND_READOUT;
                else
                    k = KIND_UNUSED;
                if (k == KIND_ENQUEUE)
                    send_item(k, pick_value(75));
                else if (k == KIND_REMOVE)
                    send_item(k, pick_value(85));
                else
                    send_item(k, $urandom);
                sent++;
            end
            if ($urandom_range(0, 3) == 0)
                wait_for_results();
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        checker_i.report_leftovers();
        @(negedge clk);

        $display("run: %0d enqueue, %0d remove, %0d read-out, %0d unused-code requests",
                 n_enqueue, n_remove, n_readout, n_unused);
        $display("run: %0d results checked, %0d full drops, %0d remove misses, %0d empty reads",
                 results_seen, full_seen, miss_seen, empty_seen);
        if (fails == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/fqrv_pkg.sv
design/fqrv_ram.sv
design/fifo_queue_with_remove_by_value.sv
tb/fqrv_checker.sv
tb/testbench.sv
